// ----- rtl/spiral_order_matrix_reader_macros.svh -----
// assertion macros for the spiral matrix reader rtl
`ifndef SPIRAL_ORDER_MATRIX_READER_MACROS_SVH
`define SPIRAL_ORDER_MATRIX_READER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SOR_ASSERT(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SOR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sor_pkg.sv -----
// types, constants and helpers for the spiral matrix reader
`timescale 1ns / 1ps

package sor_pkg;

	localparam int DATA_W       = 32;
	localparam int DIM_W        = 7;
	localparam int DIM_MAX      = 2**DIM_W - 1;
	localparam int POS_W        = 6;
	localparam int CNT_W        = 2 * DIM_W;
	localparam int KIND_W       = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int OUT_TDATA_W  = 48;
	localparam int PAD_W        = OUT_TDATA_W - DATA_W - 2 * POS_W;
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD    = 2'd0,
		KIND_EMIT    = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		HEAD_RIGHT = 4'b0001,
		HEAD_DOWN  = 4'b0010,
		HEAD_LEFT  = 4'b0100,
		HEAD_UP    = 4'b1000
	} head_t;

	typedef struct packed {
		logic             emit;
		logic             wr;
		logic             status;
		logic             last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} walk_ctl_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] dim,
		input logic [DIM_W-1:0] cap);
		logic [DIM_W-1:0] res;
		if (dim == '0) begin
			res = DIM_W'(1);
		end else if (dim > cap) begin
			res = cap;
		end else begin
			res = dim;
		end
		return res;
	endfunction

endpackage

// ----- rtl/sor_store.sv -----
// single-port element store with registered read data
`timescale 1ns / 1ps

module sor_store #(
	parameter int DEPTH = sor_pkg::DEF_MAX_ROWS * sor_pkg::DEF_MAX_COLS,
	parameter int AW    = 12
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic                      re,
	input  logic [AW-1:0]             addr,
	input  logic [sor_pkg::DATA_W-1:0] wdata,
	output logic [sor_pkg::DATA_W-1:0] rdata
);
	import sor_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- rtl/sor_walk.sv -----
// dimension registers, load counter and spiral position sequencer
`timescale 1ns / 1ps

module sor_walk #(
	parameter int MAX_ROWS = sor_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = sor_pkg::DEF_MAX_COLS,
	parameter int AW       = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sor_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sor_pkg::DIM_W-1:0]    cfg_data,
	input  logic                         step,
	input  logic [sor_pkg::KIND_W-1:0]   kind,
	output sor_pkg::walk_ctl_t           ctl,
	output logic [AW-1:0]                addr
);
	import sor_pkg::*;

	localparam logic [DIM_W-1:0] CAP_ROWS = DIM_W'((MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS);
	localparam logic [DIM_W-1:0] CAP_COLS = DIM_W'((MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS);

	logic [DIM_W-1:0] rows_q, cols_q;
	logic [CNT_W-1:0] load_cnt_q, emit_cnt_q;
	logic [POS_W-1:0] row_q, col_q;
	logic [POS_W-1:0] top_q, bot_q, left_q, right_q;
	head_t            head_q;

	logic [DIM_W-1:0] eff_r, eff_c, rows_nx, cols_nx, eff_nr, eff_nc;
	logic [CNT_W-1:0] total, lin;
	kind_t            kind_c;
	logic             do_load, is_emit, bad, good, is_last;

	assign kind_c  = kind_t'(kind);
	assign eff_r   = eff_dim(rows_q, CAP_ROWS);
	assign eff_c   = eff_dim(cols_q, CAP_COLS);
	assign total   = {{DIM_W{1'b0}}, eff_r} * {{DIM_W{1'b0}}, eff_c};
	assign lin     = {{(CNT_W-POS_W){1'b0}}, row_q} * {{DIM_W{1'b0}}, eff_c}
		+ {{(CNT_W-POS_W){1'b0}}, col_q};

	assign rows_nx = (cfg_index == REG_ROWS) ? cfg_data : rows_q;
	assign cols_nx = (cfg_index == REG_COLS) ? cfg_data : cols_q;
	assign eff_nr  = eff_dim(rows_nx, CAP_ROWS);
	assign eff_nc  = eff_dim(cols_nx, CAP_COLS);

	assign do_load = step && (kind_c == KIND_LOAD) && (load_cnt_q < total);
	assign is_emit = step && (kind_c == KIND_EMIT);
	assign bad     = (load_cnt_q < total) || (emit_cnt_q >= total);
	assign good    = is_emit && !bad;
	assign is_last = (emit_cnt_q + CNT_W'(1)) == total;

	always_comb begin
		ctl.emit   = is_emit;
		ctl.wr     = do_load;
		ctl.status = bad;
		ctl.last   = !bad && is_last;
		ctl.row    = bad ? '0 : row_q;
		ctl.col    = bad ? '0 : col_q;
		addr       = do_load ? AW'(load_cnt_q) : AW'(lin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= DIM_W'(1);
			cols_q     <= DIM_W'(1);
			load_cnt_q <= '0;
			emit_cnt_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			head_q     <= HEAD_RIGHT;
			top_q      <= '0;
			left_q     <= '0;
			bot_q      <= '0;
			right_q    <= '0;
		end else if (cfg_we) begin
			rows_q     <= rows_nx;
			cols_q     <= cols_nx;
			load_cnt_q <= '0;
			emit_cnt_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			head_q     <= HEAD_RIGHT;
			top_q      <= '0;
			left_q     <= '0;
			bot_q      <= POS_W'(eff_nr - DIM_W'(1));
			right_q    <= POS_W'(eff_nc - DIM_W'(1));
		end else if (step) begin
			unique case (kind_c)
				KIND_LOAD: begin
					if (do_load) begin
						load_cnt_q <= load_cnt_q + CNT_W'(1);
					end
				end
				KIND_EMIT: begin
					if (good) begin
						emit_cnt_q <= emit_cnt_q + CNT_W'(1);
						if (!is_last) begin
							unique case (head_q)
								HEAD_RIGHT: begin
									if (col_q < right_q) begin
										col_q <= col_q + POS_W'(1);
									end else begin
										top_q  <= top_q + POS_W'(1);
										head_q <= HEAD_DOWN;
										row_q  <= row_q + POS_W'(1);
									end
								end
								HEAD_DOWN: begin
									if (row_q < bot_q) begin
										row_q <= row_q + POS_W'(1);
									end else begin
										right_q <= right_q - POS_W'(1);
										head_q  <= HEAD_LEFT;
										col_q   <= col_q - POS_W'(1);
									end
								end
								HEAD_LEFT: begin
									if (col_q > left_q) begin
										col_q <= col_q - POS_W'(1);
									end else begin
										bot_q  <= bot_q - POS_W'(1);
										head_q <= HEAD_UP;
										row_q  <= row_q - POS_W'(1);
									end
								end
								HEAD_UP: begin
									if (row_q > top_q) begin
										row_q <= row_q - POS_W'(1);
									end else begin
										left_q <= left_q + POS_W'(1);
										head_q <= HEAD_RIGHT;
										col_q  <= col_q + POS_W'(1);
									end
								end
								default: begin
									head_q <= HEAD_RIGHT;
								end
							endcase
						end
					end
				end
				KIND_RESTART: begin
					load_cnt_q <= '0;
					emit_cnt_q <= '0;
					row_q      <= '0;
					col_q      <= '0;
					head_q     <= HEAD_RIGHT;
					top_q      <= '0;
					left_q     <= '0;
					bot_q      <= POS_W'(eff_r - DIM_W'(1));
					right_q    <= POS_W'(eff_c - DIM_W'(1));
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/spiral_order_matrix_reader.sv -----
// Spiral matrix reader: loads a rows x cols matrix row-major into a store and
// reads it back in clockwise spiral order, one element per emit request.
// Configuration: cfg_we/cfg_index/cfg_data write rows (index 0) or cols
// (index 1); each write also restarts the load and the spiral.
// Input stream s_*: s_tuser selects load, emit or restart, s_tdata carries
// the element value of a load. Loads and restarts give no result.
// Output stream m_*: one transaction per emit, carrying value, row, column,
// tlast on the final spiral element and tuser set for an early or late emit.
// Pipeline: the store is read at the edge that accepts an emit; the output
// register loads from the read stage once it is empty or m_tready is high.
// Throughput is one item per cycle unless the output stalls, bounded by
// the single store port, which serves either the write of a load or the
// read of an emit in each cycle.
// Reset clears the counters, the spiral position and sets rows = cols = 1;
// the store contents are undefined until loaded.
// When m_tready is low, the output register holds its result and one more
// emit may wait in the read stage; s_tready drops once both are occupied.
`timescale 1ns / 1ps
`include "spiral_order_matrix_reader_macros.svh"

module spiral_order_matrix_reader #(
	parameter int MAX_ROWS = sor_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = sor_pkg::DEF_MAX_COLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sor_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sor_pkg::DIM_W-1:0]        cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sor_pkg::DATA_W-1:0]       s_tdata,   // value
	input  logic [sor_pkg::KIND_W-1:0]       s_tuser,   // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sor_pkg::OUT_TDATA_W-1:0]  m_tdata,   // value_res, row, col, zero pad
	output logic                             m_tlast,
	output logic [0:0]                       m_tuser    // status
);
	import sor_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	walk_ctl_t         ctl, meta_s1;
	logic [AW-1:0]     addr;
	logic [DATA_W-1:0] rdata;
	logic              s_fire, valid_s1, s1_move, m_tvalid_q;

	assign s_fire   = s_tvalid && s_tready;
	assign s1_move  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || s1_move;
	assign m_tvalid = m_tvalid_q;

	sor_walk #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.AW      (AW)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (s_fire),
		.kind     (s_tuser),
		.ctl      (ctl),
		.addr     (addr)
	);

	sor_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (ctl.wr),
		.re   (ctl.emit && !ctl.status),
		.addr (addr),
		.wdata(s_tdata),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			valid_s1   <= ctl.emit || (valid_s1 && !s1_move);
			m_tvalid_q <= s1_move || (m_tvalid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			meta_s1 <= ctl;
		end
		if (s1_move) begin
			m_tdata <= {{PAD_W{1'b0}}, meta_s1.col, meta_s1.row,
				meta_s1.status ? {DATA_W{1'b0}} : rdata};
			m_tlast <= meta_s1.last;
			m_tuser <= meta_s1.status;
		end
	end

	`SOR_ASSERT(a_err_zero, !(m_tvalid && m_tuser[0]) || (m_tdata == '0 && !m_tlast), "error result carries payload")
	`SOR_ASSERT_NEXT(a_emit_to_s1, s_fire && s_tuser == KIND_EMIT, valid_s1, "accepted emit not captured")
	`SOR_ASSERT_NEXT(a_other_no_s1, s_fire && s_tuser != KIND_EMIT && !valid_s1, !valid_s1, "non-emit item produced a result")
	`SOR_ASSERT(a_emit_has_room, !ctl.emit || !valid_s1 || s1_move, "emit issued into occupied read stage")

endmodule

// ----- test/spiral_order_matrix_reader_checker.sv -----
// checker for the spiral matrix reader: predicts every emitted element and compares it
`timescale 1ns / 1ps

module spiral_order_matrix_reader_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sor_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sor_pkg::DIM_W-1:0]        cfg_data,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [sor_pkg::DATA_W-1:0]       s_tdata,   // value
	input  logic [sor_pkg::KIND_W-1:0]       s_tuser,   // kind
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [sor_pkg::OUT_TDATA_W-1:0]  m_tdata,   // value_res, row, col, zero pad
	input  logic                             m_tlast,
	input  logic [0:0]                       m_tuser,   // status
	output int                               outstanding,
	output int                               fail_count
);

	import sor_pkg::*;

	localparam int STORE_DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         row;
		logic [POS_W-1:0]         col;
		logic                     last;
		logic                     status;
	} element_t;

	element_t                 upcoming_elements[$];
	logic signed [DATA_W-1:0] grid[STORE_DEPTH];
	logic [DIM_W-1:0]         rows_reg;
	logic [DIM_W-1:0]         cols_reg;
	int unsigned              loaded;
	int unsigned              emitted;
	logic [POS_W-1:0]         cur_r;
	logic [POS_W-1:0]         cur_c;
	logic [POS_W-1:0]         top_b;
	logic [POS_W-1:0]         bot_b;
	logic [POS_W-1:0]         left_b;
	logic [POS_W-1:0]         right_b;
	head_t                    heading;
	int                       mismatches = 0;

	assign fail_count = mismatches;

	function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] d, input int unsigned cap);
		int unsigned n;
		n = 32'(d);
		if (n == 0) begin
			n = 1;
		end else if (n > cap) begin
			n = cap;
		end
		return n;
	endfunction

	function automatic void restart_walk();
		loaded  = 0;
		emitted = 0;
		cur_r   = '0;
		cur_c   = '0;
		heading = HEAD_RIGHT;
		top_b   = '0;
		left_b  = '0;
		bot_b   = POS_W'(dim_in_use(rows_reg, DEF_MAX_ROWS) - 1);
		right_b = POS_W'(dim_in_use(cols_reg, DEF_MAX_COLS) - 1);
	endfunction

	// one clockwise step, turning at the edge of the cells not yet visited
	function automatic void step_walk();
		case (heading)
			HEAD_RIGHT: begin
				if (cur_c < right_b) begin
					cur_c = cur_c + POS_W'(1);
				end else begin
					top_b   = top_b + POS_W'(1);
					heading = HEAD_DOWN;
					cur_r   = cur_r + POS_W'(1);
				end
			end
			HEAD_DOWN: begin
				if (cur_r < bot_b) begin
					cur_r = cur_r + POS_W'(1);
				end else begin
					right_b = right_b - POS_W'(1);
					heading = HEAD_LEFT;
					cur_c   = cur_c - POS_W'(1);
				end
			end
			HEAD_LEFT: begin
				if (cur_c > left_b) begin
					cur_c = cur_c - POS_W'(1);
				end else begin
					bot_b   = bot_b - POS_W'(1);
					heading = HEAD_UP;
					cur_r   = cur_r - POS_W'(1);
				end
			end
			default: begin
				if (cur_r > top_b) begin
					cur_r = cur_r - POS_W'(1);
				end else begin
					left_b  = left_b + POS_W'(1);
					heading = HEAD_RIGHT;
					cur_c   = cur_c + POS_W'(1);
				end
			end
		endcase
	endfunction

	function automatic void apply_item(input logic [KIND_W-1:0] kind,
		input logic [DATA_W-1:0] value);
		int unsigned n_c;
		int unsigned total;
		element_t    e;
		n_c   = dim_in_use(cols_reg, DEF_MAX_COLS);
		total = dim_in_use(rows_reg, DEF_MAX_ROWS) * n_c;
		case (kind)
			KIND_LOAD: begin
				if (loaded < total) begin
					grid[loaded] = value;
					loaded++;
				end
			end
			KIND_RESTART: begin
				restart_walk();
			end
			KIND_EMIT: begin
				e = '0;
				if (loaded < total || emitted >= total) begin
					e.status = 1'b1;
				end else begin
					e.value = grid[(cur_r * n_c + cur_c) % STORE_DEPTH];
					e.row   = cur_r;
					e.col   = cur_c;
					e.last  = (emitted + 1 == total);
					emitted++;
					if (!e.last) begin
						step_walk();
					end
				end
				upcoming_elements = {upcoming_elements, e};
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		element_t want;
		if (!arst_n) begin
			upcoming_elements.delete();
			rows_reg = DIM_W'(1);
			cols_reg = DIM_W'(1);
			restart_walk();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (upcoming_elements.size() == 0) begin
					$error("unexpected result transaction: value %0d row %0d col %0d",
						$signed(m_tdata[DATA_W-1:0]), m_tdata[DATA_W +: POS_W],
						m_tdata[DATA_W+POS_W +: POS_W]);
					mismatches++;
				end else begin
					want = upcoming_elements.pop_front();
					check_field("value_res", want.value, $signed(m_tdata[DATA_W-1:0]));
					check_field("row", want.row, m_tdata[DATA_W +: POS_W]);
					check_field("col", want.col, m_tdata[DATA_W+POS_W +: POS_W]);
					check_field("last", want.last, m_tlast);
					check_field("status", want.status, m_tuser);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_ROWS) begin
					rows_reg = cfg_data;
				end else begin
					cols_reg = cfg_data;
				end
				restart_walk();
			end
			if (s_tvalid && s_tready) begin
				apply_item(s_tuser, s_tdata);
			end
			outstanding <= upcoming_elements.size();
		end
	end

endmodule

// ----- test/tb.sv -----
// testbench top for the spiral matrix reader: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;

	import sor_pkg::*;

	localparam int               CLK_LIMIT   = 500_000;
	localparam int               TAIL        = 8;
	localparam int               LONG_HOLD   = 200;
	localparam int               PHASE_ITEMS = 300;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [DIM_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata;
	logic [KIND_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic [0:0]             m_tuser;
	int                     outstanding;
	int                     fail_count;
	int                     src_idle_pct;
	int                     sink_stall_pct;
	bit                     hold_req;
	int unsigned            items_sent;
	int unsigned            cell_total;
	int unsigned            cycles;

	spiral_order_matrix_reader i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	spiral_order_matrix_reader_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CLK_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// receiver: random stalls plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	function automatic int unsigned dim_count(input logic [DIM_W-1:0] d);
		int unsigned n;
		n = 32'(d);
		if (n == 0) begin
			n = 1;
		end else if (n > DEF_MAX_ROWS) begin
			n = DEF_MAX_ROWS;
		end
		return n;
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(15))
			0: return '0;
			1: return DIM_W'(DIM_MAX);
			2: return DIM_W'(DEF_MAX_ROWS);
			3, 4: return DIM_W'($urandom_range(9, 63));
			default: return DIM_W'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic push_item(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			s_tuser  <= KIND_W'($urandom);
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		if (k != KIND_UNUSED) begin
			items_sent++;
		end
	endtask

	// hold the input back until every expected element has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
		drain();
		write_reg(REG_ROWS, r);
		write_reg(REG_COLS, c);
		cell_total = dim_count(r) * dim_count(c);
	endtask

	task automatic load_cells(input bit noisy);
		int unsigned i;
		bit          restarted;
		i         = 0;
		restarted = 1'b0;
		while (i < cell_total) begin
			if (noisy && $urandom_range(15) == 0) begin
				case ($urandom_range(2))
					0: push_item(KIND_UNUSED, $urandom);
					1: push_item(KIND_EMIT, $urandom);
					default: begin
						if (!restarted) begin
							push_item(KIND_RESTART, $urandom);
							restarted = 1'b1;
							i         = 0;
						end
					end
				endcase
			end else begin
				push_item(KIND_LOAD, rand_value());
				i++;
			end
		end
	endtask

	task automatic emit_cells(input int unsigned n);
		repeat (n) push_item(KIND_EMIT, $urandom);
	endtask

	task automatic matrix_session(input bit noisy);
		push_item(KIND_RESTART, $urandom);
		load_cells(noisy);
		if (noisy && $urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3)) push_item(KIND_LOAD, rand_value());
		end
		// restart partway through the spiral and walk a fresh matrix
		if (noisy && $urandom_range(4) == 0) begin
			emit_cells($urandom_range(cell_total - 1));
			push_item(KIND_RESTART, $urandom);
			load_cells(1'b0);
		end
		emit_cells(cell_total + (noisy ? $urandom_range(2) : 0));
	endtask

	task automatic random_session();
		logic [DIM_W-1:0] r;
		logic [DIM_W-1:0] c;
		r = pick_dim();
		c = pick_dim();
		if (dim_count(r) > 8 && dim_count(c) > 8) begin
			c = DIM_W'($urandom_range(0, 4));
		end
		if ($urandom_range(2) != 0) begin
			set_dims(r, c);
		end
		matrix_session(1'b1);
	endtask

	initial begin
		int unsigned goal;
		cfg_we         = 1'b0;
		cfg_index      = REG_ROWS;
		cfg_data       = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		hold_req       = 1'b0;
		items_sent     = 0;
		cell_total     = 1;
		src_idle_pct   = 25;
		sink_stall_pct = 88;
		arst_n         = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// single cell after reset: early, normal, late emits and ignored items
		push_item(KIND_EMIT, $urandom);
		push_item(KIND_LOAD, 32'h8000_0000);
		push_item(KIND_LOAD, 32'h1234_5678);
		push_item(KIND_EMIT, '0);
		push_item(KIND_EMIT, '1);
		push_item(KIND_UNUSED, '1);
		push_item(KIND_RESTART, '0);
		push_item(KIND_EMIT, $urandom);
		push_item(KIND_LOAD, 32'h7fff_ffff);
		push_item(KIND_EMIT, $urandom);
		set_dims(DIM_W'(2), DIM_W'(3));
		matrix_session(1'b0);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct   = 25;
					sink_stall_pct = 88;
				end
				1: begin
					src_idle_pct   = 88;
					sink_stall_pct = 25;
				end
				default: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
			endcase
			if (ph == 0) begin
				// zero rows and an oversized column count, walked under a long output stall
				set_dims('0, DIM_W'(DIM_MAX));
				push_item(KIND_RESTART, $urandom);
				load_cells(1'b0);
				hold_req = 1'b1;
				emit_cells(cell_total + 1);
				drain();
			end
			if (ph == 2) begin
				// full row count with a narrow matrix
				set_dims(DIM_W'(DEF_MAX_ROWS), DIM_W'(2));
				matrix_session(1'b0);
			end
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				random_session();
			end
		end
		drain();

		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sor_pkg.sv
rtl/sor_store.sv
rtl/sor_walk.sv
rtl/spiral_order_matrix_reader.sv
test/spiral_order_matrix_reader_checker.sv
test/tb.sv
